/* design/ascii_substring_matcher_unit_assert.svh */
// Assertion macros for the substring matcher.
// Included by ascii_substring_matcher_unit.sv; expects clk and rst_n in scope.
`ifndef ASCII_SUBSTRING_MATCHER_UNIT_ASSERT_SVH
`define ASCII_SUBSTRING_MATCHER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define ASM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASM_ASSERT(label, prop, msg)
`define ASM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* design/assm_pkg.sv */
`timescale 1ns / 1ps
// Package for the substring matcher: command codes, defaults, case folding.
// No dependencies.
package assm_pkg;

    localparam int MAX_PATTERN_DEF = 32;

    typedef enum logic [1:0] {
        CMD_PATTERN = 2'd0,
        CMD_TARGET  = 2'd1,
        CMD_END     = 2'd2
    } cmd_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold_en);
        logic [7:0] r;
        r = b;
        if (fold_en && (b inside {[8'h41:8'h5A]}))
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

/* design/ascii_substring_matcher_unit.sv */
`timescale 1ns / 1ps
// Top level of the substring matcher: pattern memory, shift-and match vector.
// Depends on assm_pkg and ascii_substring_matcher_unit_assert.svh.
//
//  channel | direction | tdata               | tuser
//  s_*     | in        | [7:0] data          | [1:0] command, [2] first
//  m_*     | out       | [0] found, [1] pattern_overflow | -
//  cfg_*   | in        | [0] case_insensitive (write only)
//
// One request per cycle sustained while s_tready stays high; each request
// passes through the registered stage behind the pattern memory read.
// A pattern write still in flight is forwarded into the next read.
// Reset clears lengths, flags and the match vector; the pattern memory holds
// no reset value. s_tready drops only while an end-of-target request waits
// on a full result register.
module ascii_substring_matcher_unit #(
    parameter int MAX_PATTERN = assm_pkg::MAX_PATTERN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data
    input  logic [2:0] s_tuser,   // [1:0] command, [2] first
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] found, [1] pattern_overflow, [7:2] zero
    input  logic       cfg_we,
    input  logic       cfg_wdata  // [0] case_insensitive
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [7:0] pat_mem [MAX_PATTERN];
    logic [7:0] pat_rd_reg [MAX_PATTERN];

    logic                   ci_reg;
    logic                   s1_valid_reg;
    assm_pkg::cmd_t         s1_cmd_reg;
    logic [7:0]             s1_data_reg;
    logic                   s1_first_reg;

    logic [LEN_W-1:0]       len_reg, len_next;
    logic [MAX_PATTERN-1:0] mv_reg, mv_next;
    logic                   found_reg, found_next;
    logic                   ovf_reg, ovf_next;
    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic                   out_ovf_reg;

    logic                   s1_adv;
    logic                   in_acc;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [LEN_W-1:0]       base_len;
    logic [7:0]             tgt;
    logic [MAX_PATTERN-1:0] eq_vec;
    logic [MAX_PATTERN-1:0] len_mask;
    logic [MAX_PATTERN-1:0] top_mask;
    logic [MAX_PATTERN-1:0] shifted;
    logic                   emit;

    assign s1_adv   = s1_valid_reg &&
                      ((s1_cmd_reg != assm_pkg::CMD_END) || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_acc   = s_tvalid && s_tready;
    assign emit     = s1_adv && (s1_cmd_reg == assm_pkg::CMD_END);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_ovf_reg, out_found_reg};

    assign base_len = s1_first_reg ? '0 : len_reg;
    assign wr_en    = s1_adv && (s1_cmd_reg == assm_pkg::CMD_PATTERN) &&
                      (base_len < LEN_W'(MAX_PATTERN));
    assign wr_addr  = base_len[IDX_W-1:0];
    assign tgt      = assm_pkg::fold_byte(s1_data_reg, ci_reg);
    assign shifted  = MAX_PATTERN'({mv_reg, 1'b1}) & eq_vec & len_mask;

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            len_mask[i] = (LEN_W'(i) < len_reg);
            top_mask[i] = (len_reg == LEN_W'(i + 1));
            eq_vec[i]   = (assm_pkg::fold_byte(pat_rd_reg[i], ci_reg) == tgt);
        end
    end

    always_comb
    begin
        len_next   = len_reg;
        mv_next    = mv_reg;
        found_next = found_reg;
        ovf_next   = ovf_reg;
        if (s1_adv)
        begin
            case (s1_cmd_reg)
                assm_pkg::CMD_PATTERN:
                begin
                    mv_next    = '0;
                    found_next = 1'b0;
                    if (s1_first_reg)
                    begin
                        ovf_next = 1'b0;
                    end
                    if (base_len < LEN_W'(MAX_PATTERN))
                    begin
                        len_next = base_len + LEN_W'(1);
                    end
                    else
                    begin
                        len_next = base_len;
                        ovf_next = 1'b1;
                    end
                end
                assm_pkg::CMD_TARGET:
                begin
                    if (len_reg != '0)
                    begin
                        mv_next = shifted;
                        if ((shifted & top_mask) != '0)
                        begin
                            found_next = 1'b1;
                        end
                    end
                end
                assm_pkg::CMD_END:
                begin
                    mv_next    = '0;
                    found_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pat_mem[wr_addr] <= s1_data_reg;
        end
        if (in_acc)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                pat_rd_reg[i] <= (wr_en && (wr_addr == IDX_W'(i))) ? s1_data_reg : pat_mem[i];
            end
            s1_cmd_reg   <= assm_pkg::cmd_t'(s_tuser[1:0]);
            s1_data_reg  <= s_tdata;
            s1_first_reg <= s_tuser[2];
        end
        if (emit)
        begin
            out_found_reg <= (len_reg == '0) || found_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ci_reg        <= 1'b0;
            s1_valid_reg  <= 1'b0;
            len_reg       <= '0;
            mv_reg        <= '0;
            found_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ci_reg <= cfg_wdata;
            end
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            len_reg   <= len_next;
            mv_reg    <= mv_next;
            found_reg <= found_next;
            ovf_reg   <= ovf_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`include "ascii_substring_matcher_unit_assert.svh"

    `ASM_ASSERT(a_len_bound, (len_reg <= LEN_W'(MAX_PATTERN)), "pattern length over capacity")
    `ASM_ASSERT(a_mv_in_len, ((mv_reg & ~len_mask) == '0),
        "match bit beyond pattern length")
    `ASM_ASSERT(a_stall_cause,
        (s_tready || (s1_cmd_reg == assm_pkg::CMD_END && out_valid_reg && !m_tready)),
        "stall without full result")
    `ASM_ASSERT_NEXT(a_pat_clears, (s1_adv && s1_cmd_reg == assm_pkg::CMD_PATTERN),
        (mv_reg == '0 && !found_reg), "pattern request left match state")

endmodule

/* tb/substring_match_checker.sv */
`timescale 1ns / 1ps
// Checker for the substring matcher: tracks pattern, match vector and flags
// from accepted requests and compares each result. Depends on assm_pkg.
module substring_match_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data
    input  logic [2:0] s_tuser,   // [1:0] command, [2] first
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [0] found, [1] pattern_overflow
    input  logic       cfg_we,
    input  logic       cfg_wdata, // [0] case_insensitive
    output int         error_count,
    output int         pending_results
);

    localparam int DEPTH = assm_pkg::MAX_PATTERN_DEF;

    typedef struct packed {
        logic found;
        logic overflow;
    } verdict_t;

    logic [7:0]       pat_mem [DEPTH];
    int unsigned      pat_len = 0;
    logic [DEPTH-1:0] hits = '0;
    logic             seen = 1'b0;
    logic             ovf = 1'b0;
    logic             fold_en = 1'b0;
    verdict_t         expected_verdicts [$];
    verdict_t         got_v;
    verdict_t         want_v;
    int               mismatches = 0;
    int               waiting = 0;

    assign error_count = mismatches;
    assign pending_results = waiting;

    function automatic logic [7:0] to_lower(input logic [7:0] b, input logic en);
        return (en && (b inside {[8'h41:8'h5A]})) ? (b | 8'h20) : b;
    endfunction

    task automatic advance_match(input logic [1:0] cmd, input logic [7:0] b,
                                 input logic restart);
        logic [DEPTH-1:0] eq;
        logic [7:0]       t;
        verdict_t         v;
        eq = '0;
        t = to_lower(b, fold_en);
        if (cmd == assm_pkg::CMD_PATTERN)
        begin
            if (restart)
            begin
                pat_len = 0;
                ovf = 1'b0;
            end
            hits = '0;
            seen = 1'b0;
            if (pat_len < DEPTH)
            begin
                pat_mem[pat_len] = b;
                pat_len++;
            end
            else
            begin
                ovf = 1'b1;
            end
        end
        else if (cmd == assm_pkg::CMD_TARGET && pat_len != 0)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (i < pat_len && to_lower(pat_mem[i], fold_en) == t)
                begin
                    eq[i] = 1'b1;
                end
            end
            hits = {hits[DEPTH-2:0], 1'b1} & eq;
            if (hits[pat_len-1])
            begin
                seen = 1'b1;
            end
        end
        else if (cmd == assm_pkg::CMD_END)
        begin
            v.found = (pat_len == 0) || seen;
            v.overflow = ovf;
            expected_verdicts.push_back(v);
            hits = '0;
            seen = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len = 0;
            hits = '0;
            seen = 1'b0;
            ovf = 1'b0;
            fold_en = 1'b0;
            expected_verdicts.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_v.found = m_tdata[0];
                got_v.overflow = m_tdata[1];
                if (expected_verdicts.size() == 0)
                begin
                    $error("unexpected result: tdata=%h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want_v = expected_verdicts.pop_front();
                    if (got_v.found !== want_v.found)
                    begin
                        $error("found: expected %0d, actual %0d", want_v.found, got_v.found);
                        mismatches++;
                    end
                    if (got_v.overflow !== want_v.overflow)
                    begin
                        $error("pattern_overflow: expected %0d, actual %0d",
                               want_v.overflow, got_v.overflow);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                advance_match(s_tuser[1:0], s_tdata, s_tuser[2]);
            end
            if (cfg_we)
            begin
                fold_en = cfg_wdata;
            end
        end
        waiting = expected_verdicts.size();
    end

endmodule

/* tb/tb_ascii_substring_matcher_unit.sv */
`timescale 1ns / 1ps
// Testbench top for the substring matcher: directed and random request
// streams with random idling. Depends on assm_pkg, the RTL and the checker.
module tb_ascii_substring_matcher_unit;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] data
    logic [2:0] s_tuser;   // [1:0] command, [2] first
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [0] found, [1] pattern_overflow
    logic       cfg_we;
    logic       cfg_wdata; // [0] case_insensitive
    int         error_count;
    int         pending_results;

    logic       quiet = 1'b0;
    int         n_sent = 0;
    logic [7:0] pat_bytes [$];

    ascii_substring_matcher_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    substring_match_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .error_count    (error_count),
        .pending_results(pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_ascii_substring_matcher_unit: errors");
        $finish;
    end

    // result-side backpressure
    initial
    begin
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic put_request(input logic [1:0] cmd, input logic [7:0] b,
                               input logic restart);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tuser = {restart, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic load_text(input logic [1:0] cmd, input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            put_request(cmd, s[i], (cmd == assm_pkg::CMD_PATTERN) && (i == 0));
        end
    endtask

    task automatic set_fold(input logic v);
        s_tvalid = 1'b0;
        while (pending_results != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [7:0] maybe_flip(input logic [7:0] b);
        if ((b inside {[8'h41:8'h5A], [8'h61:8'h7A]}) && $urandom_range(0, 1) == 1)
        begin
            return b ^ 8'h20;
        end
        return b;
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 99) < 70)
        begin
            return maybe_flip(8'h61 + 8'($urandom_range(0, 2)));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // one pattern load (optional), one target scan, one end of target, or else one random request
    task automatic random_run();
        logic [7:0] b;
        int         n;
        int         k;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            put_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
            return;
        end
        if (r < 88 || pat_bytes.size() == 0)
        begin
            k = $urandom_range(0, 99);
            n = (k < 85) ? $urandom_range(1, 5) :
                (k < 95) ? $urandom_range(6, 31) : $urandom_range(32, 36);
            pat_bytes.delete();
            for (int i = 0; i < n; i++)
            begin
                b = pick_byte();
                pat_bytes.push_back(b);
                put_request(assm_pkg::CMD_PATTERN, b, i == 0);
            end
        end
        n = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 40 : 12);
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 15)
            begin
                for (int j = 0; j < pat_bytes.size() && j < assm_pkg::MAX_PATTERN_DEF; j++)
                begin
                    put_request(assm_pkg::CMD_TARGET, maybe_flip(pat_bytes[j]),
                                1'($urandom_range(0, 1)));
                end
            end
            else if (k < 55)
            begin
                b = pat_bytes[$urandom_range(0, pat_bytes.size() - 1)];
                put_request(assm_pkg::CMD_TARGET, maybe_flip(b), 1'($urandom_range(0, 1)));
            end
            else
            begin
                put_request(assm_pkg::CMD_TARGET, pick_byte(), 1'($urandom_range(0, 1)));
            end
        end
        put_request(assm_pkg::CMD_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_fold(1'b0);
        // empty pattern matches, with and without target bytes
        put_request(assm_pkg::CMD_END, 8'hFF, 1'b1);
        put_request(assm_pkg::CMD_TARGET, 8'h78, 1'b1);
        put_request(assm_pkg::CMD_END, 8'h00, 1'b0);
        // exact-case compare
        load_text(assm_pkg::CMD_PATTERN, "aB");
        load_text(assm_pkg::CMD_TARGET, "xab");
        put_request(assm_pkg::CMD_END, 8'h00, 1'b0);
        load_text(assm_pkg::CMD_TARGET, "zaB");
        put_request(assm_pkg::CMD_END, 8'h00, 1'b0);
        // unused command and stray first flag are ignored
        put_request(CMD_UNUSED, 8'hFF, 1'b1);
        put_request(assm_pkg::CMD_TARGET, 8'h61, 1'b1);
        put_request(assm_pkg::CMD_TARGET, 8'h42, 1'b1);
        put_request(assm_pkg::CMD_END, 8'h00, 1'b1);
        // pattern longer than target
        put_request(assm_pkg::CMD_PATTERN, 8'h00, 1'b1);
        put_request(assm_pkg::CMD_PATTERN, 8'hFF, 1'b0);
        put_request(assm_pkg::CMD_TARGET, 8'h00, 1'b0);
        put_request(assm_pkg::CMD_END, 8'h00, 1'b0);
        // pattern byte mid-scan abandons the scan
        put_request(assm_pkg::CMD_TARGET, 8'h00, 1'b0);
        put_request(assm_pkg::CMD_PATTERN, 8'hFF, 1'b0);
        put_request(assm_pkg::CMD_TARGET, 8'hFF, 1'b0);
        put_request(assm_pkg::CMD_END, 8'h00, 1'b0);

        set_fold(1'b1);
        load_text(assm_pkg::CMD_PATTERN, "Ab");
        load_text(assm_pkg::CMD_TARGET, "aB");
        put_request(assm_pkg::CMD_END, 8'h00, 1'b0);

        for (int ph = 0; ph < 4; ph++)
        begin
            set_fold(ph[0]);
            quiet = (ph == 3);
            while (n_sent < 300 + ph * 285) random_run();
        end
        s_tvalid = 1'b0;

        while (pending_results != 0) @(negedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_results == 0)
        begin
            $display("tb_ascii_substring_matcher_unit: clean");
        end
        else
        begin
            $display("tb_ascii_substring_matcher_unit: errors");
        end
        $finish;
    end

endmodule
